/* hdl/scs_pkg.sv */
// Shared constants, codes and control types of the sorted code set.
`timescale 1ns / 1ps

package scs_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int CMD_W    = 3;
  localparam int CODE_W   = 17;
  localparam int GROUP_W  = 7;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 6;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 3;

  localparam int GROUP_DIV_INT = 1000;

  localparam logic [CODE_W-1:0] CODE_MIN   = CODE_W'(10000);
  localparam logic [CODE_W-1:0] CODE_MAX   = CODE_W'(99999);
  localparam logic [CODE_W-1:0] GROUP_DIV  = CODE_W'(GROUP_DIV_INT);
  localparam logic [CODE_W-1:0] GROUP_SPAN = CODE_W'(GROUP_DIV_INT - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(CAPACITY);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT     = 3'd0,
    CMD_DELETE     = 3'd1,
    CMD_SEARCH     = 3'd2,
    CMD_LIST_GROUP = 3'd3,
    CMD_LIST_ALL   = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STS_DONE    = 2'd0,
    STS_PRESENT = 2'd1,
    STS_FULL    = 2'd2,
    STS_ABSENT  = 2'd3
  } stat_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;         // capture the input word, start an ascending walk
    logic scan;         // advance the ascending walk
    logic shift_start;  // start the descending walk for an insert
    logic shift;        // advance the descending walk
    logic fin_push;     // load the final result into the output register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic walk_done;
    logic need_shift;
    logic ins_fin;
    logic out_free;
  } dp_sts_t;

endpackage

/* hdl/sorted_code_set.sv */
// Top level of the sorted code set: stream ports, controller and datapath.
`timescale 1ns / 1ps
//
// Holds an ascending set of five-digit codes, no duplicates, up to CAPACITY
// entries. Each input word carries one command in s_axis_tuser: insert,
// delete, search, list one group (code / 1000 == group) or list all.
// Single commands return one word; a list returns one word per matching entry
// in ascending order with tlast on the final one, or one empty word (entry_valid
// low) when nothing matches. Unknown commands return one empty word.
// Flow: every command first walks the table once through the single read
// port of the table memory; an insert then shifts larger entries up one slot
// a cycle. A final step loads the result into the output register, and the
// next word is taken from the cycle after that; a list streams one matching
// entry per cycle while the receiver takes each word. The input is taken
// only while no command is in progress, but a finished result may still sit
// in the output register while the next word is accepted.
// Reset empties the table at once (count to zero); no clearing pass runs.
// When the receiver stalls, hold the output word; a list walk pauses until the
// output register frees up, nothing is dropped.

module sorted_code_set import scs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [16:0] code, [23:17] group
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [2:0] command
  input  logic [CMD_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [16:0] entry_code, [22:17] stored_count, [23] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [0] entry_valid, [2:1] status
  output logic [OUT_USER_W-1:0] m_axis_tuser,
  output logic                  m_axis_tlast
);

  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic [CODE_W-1:0]  out_code;
  logic               out_entry_valid;
  stat_e              out_status;
  logic [COUNT_W-1:0] out_count;

  scs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  scs_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_cmd_i          (s_axis_tuser),
    .in_code_i         (s_axis_tdata[CODE_W-1:0]),
    .in_group_i        (s_axis_tdata[CODE_W+GROUP_W-1:CODE_W]),
    .out_ready_i       (m_axis_tready),
    .out_valid_o       (m_axis_tvalid),
    .out_code_o        (out_code),
    .out_entry_valid_o (out_entry_valid),
    .out_status_o      (out_status),
    .out_count_o       (out_count),
    .out_last_o        (m_axis_tlast)
  );

  // Pack the result word: code low, count above it, pad with zeros.
  assign m_axis_tdata = {{(OUT_DATA_W - CODE_W - COUNT_W){1'b0}}, out_count, out_code};
  assign m_axis_tuser = {out_status, out_entry_valid};

endmodule

/* hdl/scs_ctrl.sv */
// Controller state machine of the sorted code set.
`timescale 1ns / 1ps

module scs_ctrl import scs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_FIN   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.walk_done) begin
          if (sts_i.need_shift) begin
            cmd_o.shift_start = 1'b1;
            state_d           = S_SHIFT;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.ins_fin) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.fin_push = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Only one walk runs at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.scan && cmd_o.shift))
    else $error("scan and shift walks active together");

  // A new word is taken only after the previous one has pushed its final result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin_push |=> (state_q == S_IDLE))
    else $error("final push did not return to idle");

  // An insert shift only follows a finished scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.shift_start |-> sts_i.walk_done)
    else $error("shift started before scan finished");

endmodule

/* hdl/scs_dpath.sv */
// Datapath of the sorted code set: table memory, walk pipeline, result register.
`timescale 1ns / 1ps

module scs_dpath import scs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  input  logic [CMD_W-1:0]   in_cmd_i,
  input  logic [CODE_W-1:0]  in_code_i,
  input  logic [GROUP_W-1:0] in_group_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [CODE_W-1:0]  out_code_o,
  output logic               out_entry_valid_o,
  output stat_e              out_status_o,
  output logic [COUNT_W-1:0] out_count_o,
  output logic               out_last_o
);

  logic [CODE_W-1:0] mem [CAPACITY];

  cmd_e              cmd_q;
  logic [CODE_W-1:0] code_q, grp_lo_q, grp_hi_q, rd_q, pend_code_q;
  logic              in_range_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d, rem_q, fin_cnt;
  logic [IDX_W-1:0]  addr_q, didx_q;
  logic              dv_q, found_q, pend_vld_q, ins_done_q;

  logic              o_vld_q, o_valid_q, o_last_q;
  logic [CODE_W-1:0] o_code_q;
  stat_e             o_stat_q;
  logic [COUNT_W-1:0] o_cnt_q;

  logic              is_list, in_grp, list_hit, out_free, stall, step, proc, gt;
  logic              walk_done, ins_fin, rd_en, push_list;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [CODE_W-1:0] wr_data;
  logic [CODE_W-1:0] grp_lo_d;

  logic [CODE_W-1:0] fin_code;
  logic              fin_valid;
  stat_e             fin_stat;

  always_comb begin
    is_list   = (cmd_q == CMD_LIST_GROUP) || (cmd_q == CMD_LIST_ALL);
    in_grp    = (rd_q >= grp_lo_q) && (rd_q <= grp_hi_q);
    list_hit  = dv_q && is_list && ((cmd_q == CMD_LIST_ALL) || in_grp);
    out_free  = !o_vld_q || out_ready_i;
    stall     = list_hit && pend_vld_q && !out_free;
    step      = (cmd_i.scan && !stall) || cmd_i.shift;
    proc      = cmd_i.scan && !stall && dv_q;
    gt        = rd_q > code_q;
    walk_done = (rem_q == '0) && !dv_q;
    ins_fin   = cmd_i.shift && ((dv_q && !gt) || walk_done);
    rd_en     = step && (rem_q != '0) && !cmd_i.load && !cmd_i.shift_start;
    push_list = proc && list_hit && pend_vld_q;
    grp_lo_d  = CODE_W'(in_group_i) * GROUP_DIV;
  end

  // Memory write: close the gap on delete, open a slot on insert.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = didx_q;
    wr_data = rd_q;
    if (proc && (cmd_q == CMD_DELETE) && found_q) begin
      wr_en   = 1'b1;
      wr_addr = didx_q - 1'b1;
    end else if (cmd_i.shift) begin
      if (dv_q) begin
        wr_en   = 1'b1;
        wr_addr = didx_q + 1'b1;
        wr_data = gt ? rd_q : code_q;
      end else if (walk_done) begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = code_q;
      end
    end
  end

  // Final single result of the command.
  always_comb begin
    fin_code  = code_q;
    fin_valid = 1'b0;
    fin_stat  = STS_DONE;
    fin_cnt   = cnt_q;
    case (cmd_q)
      CMD_INSERT: begin
        if (!in_range_q) begin
          fin_stat = STS_ABSENT;
        end else if (found_q) begin
          fin_valid = 1'b1;
          fin_stat  = STS_PRESENT;
        end else if (ins_done_q) begin
          fin_valid = 1'b1;
        end else begin
          fin_stat = STS_FULL;
        end
      end
      CMD_DELETE: begin
        fin_valid = found_q;
        fin_stat  = found_q ? STS_DONE : STS_ABSENT;
        if (found_q) begin
          fin_cnt = cnt_q - 1'b1;
        end
      end
      CMD_SEARCH: begin
        fin_valid = found_q;
        fin_stat  = found_q ? STS_DONE : STS_ABSENT;
      end
      CMD_LIST_GROUP, CMD_LIST_ALL: begin
        fin_valid = pend_vld_q;
        fin_code  = pend_vld_q ? pend_code_q : '0;
      end
      default: begin
        fin_code = '0;
      end
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.fin_push) begin
      cnt_d = fin_cnt;
    end else if (ins_fin) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_comb begin
    sts_o.walk_done  = walk_done;
    sts_o.need_shift = (cmd_q == CMD_INSERT) && in_range_q && !found_q &&
                       (cnt_q < CNT_FULL);
    sts_o.ins_fin    = ins_fin;
    sts_o.out_free   = out_free;
  end

  // Table memory, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q   <= mem[addr_q];
      didx_q <= addr_q;
    end
  end

  // Command operands and walk address.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q      <= cmd_e'(in_cmd_i);
      code_q     <= in_code_i;
      in_range_q <= (in_code_i >= CODE_MIN) && (in_code_i <= CODE_MAX);
      grp_lo_q   <= grp_lo_d;
      grp_hi_q   <= grp_lo_d + GROUP_SPAN;
      addr_q     <= '0;
    end else if (cmd_i.shift_start) begin
      addr_q <= IDX_W'(cnt_q - 1'b1);
    end else if (rd_en) begin
      addr_q <= cmd_i.shift ? addr_q - 1'b1 : addr_q + 1'b1;
    end
    if (proc && list_hit) begin
      pend_code_q <= rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      rem_q      <= '0;
      dv_q       <= 1'b0;
      found_q    <= 1'b0;
      pend_vld_q <= 1'b0;
      ins_done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.load || cmd_i.shift_start) begin
        rem_q <= cnt_q;
        dv_q  <= 1'b0;
      end else if (step) begin
        dv_q <= rd_en;
        if (rd_en) begin
          rem_q <= rem_q - 1'b1;
        end
      end
      if (cmd_i.load) begin
        found_q    <= 1'b0;
        pend_vld_q <= 1'b0;
        ins_done_q <= 1'b0;
      end else begin
        if (proc && (rd_q == code_q)) begin
          found_q <= 1'b1;
        end
        if (proc && list_hit) begin
          pend_vld_q <= 1'b1;
        end
        if (ins_fin) begin
          ins_done_q <= 1'b1;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (push_list || cmd_i.fin_push) begin
      o_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      o_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_list) begin
      o_code_q  <= pend_code_q;
      o_valid_q <= 1'b1;
      o_stat_q  <= STS_DONE;
      o_cnt_q   <= COUNT_W'(cnt_q);
      o_last_q  <= 1'b0;
    end else if (cmd_i.fin_push) begin
      o_code_q  <= fin_code;
      o_valid_q <= fin_valid;
      o_stat_q  <= fin_stat;
      o_cnt_q   <= COUNT_W'(fin_cnt);
      o_last_q  <= 1'b1;
    end
  end

  assign out_valid_o       = o_vld_q;
  assign out_code_o        = o_code_q;
  assign out_entry_valid_o = o_valid_q;
  assign out_status_o      = o_stat_q;
  assign out_count_o       = o_cnt_q;
  assign out_last_o        = o_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("entry count above capacity");

  // Writes stay inside the occupied region plus the slot being opened.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (CNT_W'(wr_addr) <= cnt_q))
    else $error("table write beyond occupied entries");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_list || cmd_i.fin_push) |-> out_free)
    else $error("result pushed into a full output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + 1'b1) ||
    (cnt_q + 1'b1 == $past(cnt_q)))
    else $error("entry count moved by more than one");

endmodule
